// ----- design/tam_pkg.sv -----
// ----------------------------------------------------------------------------
// tam_pkg: shared types and constants of the tetrahedron affine map block
// Holds the fixed result formats, the controller state types and the
// request/response groups between the row engine and the divider.
// ----------------------------------------------------------------------------
package tam_pkg;

  localparam int INV_FRAC  = 32;
  localparam int INV_WIDTH = 48;
  localparam int DET_FRAC  = 24;
  localparam int DET_WIDTH = 62;

  localparam logic [INV_WIDTH-1:0] INV_MAX = {1'b0, {(INV_WIDTH-1){1'b1}}};
  localparam logic [INV_WIDTH-1:0] INV_MIN = {1'b1, {(INV_WIDTH-1){1'b0}}};

  typedef enum logic [2:0] {
    F_IDLE,
    F_PROD,
    F_COF,
    F_DET,
    F_RND,
    F_PUSH
  } front_state_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_START,
    B_WAIT,
    B_EMIT
  } back_state_t;

  typedef enum logic [1:0] {
    D_IDLE,
    D_RUN,
    D_FIN
  } div_state_t;

  typedef struct packed {
    logic start;
    logic neg;
  } div_req_t;

  typedef struct packed {
    logic done;
    logic busy;
  } div_rsp_t;

endpackage

// ----- design/tam_fifo.sv -----
// ----------------------------------------------------------------------------
// tam_fifo: short request queue
// Register-based FIFO between the setup front end and the row engine.
// ----------------------------------------------------------------------------
module tam_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_valid,
  output logic             wr_ready,
  input  logic [WIDTH-1:0] din,
  output logic             rd_valid,
  input  logic             rd_ready,
  output logic [WIDTH-1:0] dout
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wptr;
  logic [AW-1:0]    rptr;
  logic [CW-1:0]    count;
  logic             push;
  logic             pop;

  assign wr_ready = (count != CW'(DEPTH));
  assign rd_valid = (count != '0);
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;
  assign dout     = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == AW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == AW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= din;
    end
  end

endmodule

// ----- design/tam_front.sv -----
// ----------------------------------------------------------------------------
// tam_front: setup front end
// Takes the corners, forms the edge matrix, all cofactors, the exact
// determinant and its rounded magnitude, then queues the request.
// ----------------------------------------------------------------------------
module tam_front import tam_pkg::*; #(
  parameter int CW = 24,
  parameter int F  = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic signed [CW-1:0]   pt [12],
  output logic                   q_valid,
  input  logic                   q_ready,
  output logic signed [CW:0]     e_q [9],
  output logic signed [CW-1:0]   p0_q [3],
  output logic signed [2*CW+2:0] cof_q [9],
  output logic [3*CW+5:0]        det_mag,
  output logic                   det_neg,
  output logic [DET_WIDTH-1:0]   abs_det_q,
  output logic                   sing_q
);

  localparam int EW   = CW + 1;
  localparam int PW   = 2 * EW;
  localparam int CFW  = PW + 1;
  localparam int DETW = 3 * CW + 6;
  localparam int L    = CW + 2;
  localparam int MAW  = CW + 3;
  localparam int MPW  = MAW + EW;
  localparam int DSH  = 3 * F - DET_FRAC;
  localparam int SW   = (DETW + 1 > DET_WIDTH + 1) ? DETW + 1 : DET_WIDTH + 1;
  localparam logic [SW-1:0] HALF =
    (DSH > 0) ? (SW'(1) << ((DSH > 0) ? DSH - 1 : 0)) : '0;

  front_state_t state;
  front_state_t state_next;

  logic signed [EW-1:0]   e   [9];
  logic signed [CW-1:0]   p0  [3];
  logic signed [PW-1:0]   pa  [9];
  logic signed [PW-1:0]   pb  [9];
  logic signed [CFW-1:0]  cof [9];
  logic signed [MPW-1:0]  mp;
  logic signed [DETW-1:0] acc;
  logic [2:0]             k;
  logic                   prev_hi;
  logic [DETW-1:0]        mag;
  logic                   neg;
  logic [DET_WIDTH-1:0]   absd;
  logic                   sing;

  logic                   in_fire;
  logic signed [MAW-1:0]  ma;
  logic signed [EW-1:0]   mb;
  logic signed [CFW-1:0]  csel;
  logic signed [DETW-1:0] term;
  logic [DETW-1:0]        mag_c;
  logic [SW-1:0]          rsum;
  logic [SW-1:0]          rsh;

  assign in_ready = (state == F_IDLE) || ((state == F_PUSH) && q_ready);
  assign in_fire  = in_valid && in_ready;
  assign q_valid  = (state == F_PUSH);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      F_IDLE: if (in_fire) state_next = F_PROD;
      F_PROD: state_next = F_COF;
      F_COF:  state_next = F_DET;
      F_DET:  if (k == 3'd6) state_next = F_RND;
      F_RND:  state_next = F_PUSH;
      F_PUSH: begin
        if (q_ready) state_next = in_fire ? F_PROD : F_IDLE;
      end
      default: state_next = F_IDLE;
    endcase
  end

  // Determinant terms: row 0 cofactors split into a low unsigned half and a
  // signed high half so each product stays near the multiplier width.
  always_comb begin
    case (k[2:1])
      2'd0:    csel = cof[0];
      2'd1:    csel = cof[1];
      default: csel = cof[2];
    endcase
    case (k[2:1])
      2'd0:    mb = e[0];
      2'd1:    mb = e[1];
      default: mb = e[2];
    endcase
    if (k[0]) begin
      ma = {{(MAW - (CFW - L)){csel[CFW-1]}}, csel[CFW-1:L]};
    end else begin
      ma = {1'b0, csel[L-1:0]};
    end
    term = {{(DETW - MPW){mp[MPW-1]}}, mp};
    if (prev_hi) begin
      term = term <<< L;
    end
    mag_c = acc[DETW-1] ? DETW'(-acc) : DETW'(acc);
    rsum  = SW'(mag_c) + HALF;
    rsh   = rsum >> DSH;
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      for (int i = 0; i < 3; i++) begin
        p0[i] <= pt[i];
        for (int j = 0; j < 3; j++) begin
          e[i*3+j] <= EW'(pt[(j+1)*3+i]) - EW'(pt[i]);
        end
      end
    end
    if (state == F_PROD) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          pa[i*3+j] <= e[((i+1)%3)*3+(j+1)%3] * e[((i+2)%3)*3+(j+2)%3];
          pb[i*3+j] <= e[((i+1)%3)*3+(j+2)%3] * e[((i+2)%3)*3+(j+1)%3];
        end
      end
    end
    if (state == F_COF) begin
      for (int n = 0; n < 9; n++) begin
        cof[n] <= CFW'(pa[n]) - CFW'(pb[n]);
      end
      acc     <= '0;
      k       <= '0;
      prev_hi <= 1'b0;
    end
    if (state == F_DET) begin
      if (k != 3'd6) begin
        mp      <= ma * mb;
        prev_hi <= k[0];
      end
      if (k != 3'd0) begin
        acc <= acc + term;
      end
      k <= k + 1'b1;
    end
    if (state == F_RND) begin
      mag  <= mag_c;
      neg  <= acc[DETW-1];
      sing <= (acc == '0);
      absd <= (|rsh[SW-1:DET_WIDTH]) ? {DET_WIDTH{1'b1}} : rsh[DET_WIDTH-1:0];
    end
  end

  assign e_q       = e;
  assign p0_q      = p0;
  assign cof_q     = cof;
  assign det_mag   = mag;
  assign det_neg   = neg;
  assign abs_det_q = absd;
  assign sing_q    = sing;

endmodule

// ----- design/tam_div.sv -----
// ----------------------------------------------------------------------------
// tam_div: serial divider for inverse entries
// Restoring division one quotient bit per cycle, round half up, then
// signed saturation to the Q16.32 range.
// ----------------------------------------------------------------------------
module tam_div import tam_pkg::*; #(
  parameter int CW = 24,
  parameter int F  = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  div_req_t             req,
  input  logic [2*CW+2:0]      num,
  input  logic [3*CW+5:0]      den,
  output div_rsp_t             rsp,
  output logic [INV_WIDTH-1:0] quot
);

  localparam int CFW  = 2 * CW + 3;
  localparam int DETW = 3 * CW + 6;
  localparam int SH   = INV_FRAC + F;
  localparam int NW   = CFW + SH;
  localparam int RW   = DETW + 1;
  localparam int QW   = INV_WIDTH + 1;
  localparam int NCW  = $clog2(NW + 1);
  localparam logic [QW:0] LIM = (QW + 1)'(1) << (INV_WIDTH - 1);

  div_state_t state;
  div_state_t state_next;

  logic [NW-1:0]  nsh;
  logic [RW-1:0]  rem;
  logic [QW-1:0]  q;
  logic           sticky;
  logic           neg;
  logic [NCW-1:0] cnt;

  logic [RW-1:0]  t;
  logic           ge;
  logic           rnd;
  logic [QW:0]    qr;
  logic           sat;
  logic [INV_WIDTH-1:0] mval;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= D_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      D_IDLE:  if (req.start) state_next = D_RUN;
      D_RUN:   if (cnt == NCW'(1)) state_next = D_FIN;
      D_FIN:   state_next = D_IDLE;
      default: state_next = D_IDLE;
    endcase
  end

  // The quotient is valid while done is high, so the caller can take it
  // at the same edge.
  always_comb begin
    t    = {rem[RW-2:0], nsh[NW-1]};
    ge   = (t >= {1'b0, den});
    rnd  = ({rem, 1'b0} >= {2'b00, den});
    qr   = {1'b0, q} + (QW + 1)'(rnd);
    sat  = neg ? (sticky || (qr > LIM)) : (sticky || (qr >= LIM));
    mval = qr[INV_WIDTH-1:0];
    if (neg) begin
      quot = sat ? INV_MIN : INV_WIDTH'(-mval);
    end else begin
      quot = sat ? INV_MAX : mval;
    end
  end

  assign rsp.done = (state == D_FIN);
  assign rsp.busy = (state != D_IDLE);

  always_ff @(posedge clk) begin
    if ((state == D_IDLE) && req.start) begin
      nsh    <= {num, {SH{1'b0}}};
      rem    <= '0;
      q      <= '0;
      sticky <= 1'b0;
      neg    <= req.neg;
      cnt    <= NCW'(NW);
    end
    if (state == D_RUN) begin
      nsh    <= nsh << 1;
      rem    <= ge ? (t - {1'b0, den}) : t;
      q      <= {q[QW-2:0], ge};
      sticky <= sticky | q[QW-1];
      cnt    <= cnt - 1'b1;
    end
  end

endmodule

// ----- design/tam_back.sv -----
// ----------------------------------------------------------------------------
// tam_back: row engine
// Pops one queued request, divides its cofactors row by row unless it is
// singular, and places each finished row in the output register.
// ----------------------------------------------------------------------------
module tam_back import tam_pkg::*; #(
  parameter int CW = 24,
  parameter int F  = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   q_valid,
  output logic                   q_pop,
  input  logic signed [CW:0]     e_q [9],
  input  logic signed [CW-1:0]   p0_q [3],
  input  logic signed [2*CW+2:0] cof_q [9],
  input  logic [3*CW+5:0]        det_mag,
  input  logic                   det_neg,
  input  logic [DET_WIDTH-1:0]   abs_det_q,
  input  logic                   sing_q,
  output logic                   o_valid,
  input  logic                   o_ready,
  output logic [1:0]             o_row,
  output logic signed [CW:0]     o_edge [3],
  output logic [INV_WIDTH-1:0]   o_inv [3],
  output logic signed [CW-1:0]   o_off,
  output logic [DET_WIDTH-1:0]   o_abs,
  output logic                   o_sing,
  output logic                   o_last
);

  localparam int CFW  = 2 * CW + 3;
  localparam int DETW = 3 * CW + 6;

  back_state_t state;
  back_state_t state_next;

  logic signed [CW:0]    we   [9];
  logic signed [CW-1:0]  wp0  [3];
  logic signed [CFW-1:0] wcof [9];
  logic [DETW-1:0]       wmag;
  logic                  wneg;
  logic [DET_WIDTH-1:0]  wabs;
  logic                  wsing;
  logic [1:0]            row;
  logic [1:0]            col;
  logic [INV_WIDTH-1:0]  inv [3];

  logic [3:0]            idx;
  logic signed [CFW-1:0] csel;
  logic [CFW-1:0]        cmag;
  logic                  emit;
  div_req_t              dreq;
  div_rsp_t              drsp;
  logic [INV_WIDTH-1:0]  dquot;

  assign idx   = {1'b0, row, 1'b0} + {2'b00, row} + {2'b00, col};
  assign csel  = wcof[idx];
  assign cmag  = csel[CFW-1] ? CFW'(-csel) : CFW'(csel);
  assign q_pop = (state == B_IDLE) && q_valid;
  assign emit  = (state == B_EMIT) && (!o_valid || o_ready);

  assign dreq.start = (state == B_START);
  assign dreq.neg   = csel[CFW-1] ^ wneg;

  tam_div #(.CW(CW), .F(F)) u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (dreq),
    .num  (cmag),
    .den  (wmag),
    .rsp  (drsp),
    .quot (dquot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE:  if (q_valid) state_next = sing_q ? B_EMIT : B_START;
      B_START: state_next = B_WAIT;
      B_WAIT:  if (drsp.done) state_next = (col == 2'd2) ? B_EMIT : B_START;
      B_EMIT: begin
        if (emit) begin
          if (row == 2'd2) state_next = B_IDLE;
          else state_next = wsing ? B_EMIT : B_START;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      we    <= e_q;
      wp0   <= p0_q;
      wcof  <= cof_q;
      wmag  <= det_mag;
      wneg  <= det_neg;
      wabs  <= abs_det_q;
      wsing <= sing_q;
      row   <= 2'd0;
      col   <= 2'd0;
    end
    if ((state == B_WAIT) && drsp.done) begin
      inv[col] <= dquot;
      if (col != 2'd2) col <= col + 1'b1;
    end
    if (emit) begin
      row <= row + 1'b1;
      col <= 2'd0;
    end
  end

  // Output register: the next row is worked on while this one waits.
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (emit) begin
      o_valid <= 1'b1;
    end else if (o_ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      o_row <= row;
      for (int j = 0; j < 3; j++) begin
        o_edge[j] <= we[{row, 1'b0} + {1'b0, row} + 4'(j)];
        o_inv[j]  <= wsing ? '0 : inv[j];
      end
      o_off  <= wp0[row];
      o_abs  <= wabs;
      o_sing <= wsing;
      o_last <= (row == 2'd2);
    end
  end

endmodule

// ----- design/tetra_affine_map_top.sv -----
// ----------------------------------------------------------------------------
// tetra_affine_map_top: affine map of one tetrahedron
// Edge matrix, inverse transpose and absolute determinant, one result per row.
// ----------------------------------------------------------------------------
// Setup runs through capture, products, cofactors, determinant, rounding and
// the push into the queue before the row engine pops the request. Each row of
// a regular matrix needs three divisions, one per inverse entry, all done by
// the single bit-serial divider over NW = 2*COORD_WIDTH + 35 + COORD_FRAC_BITS
// quotient bits (99 at the defaults); the next request waits for the last row.
// Reset clears the controllers, the queue and the output valid; no data clear.
module tetra_affine_map_top import tam_pkg::*; #(
  parameter int COORD_WIDTH     = 24,
  parameter int COORD_FRAC_BITS = 16,
  parameter int QUEUE_DEPTH     = 2
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_WIDTH-1:0] p0_x,
  input  logic signed [COORD_WIDTH-1:0] p0_y,
  input  logic signed [COORD_WIDTH-1:0] p0_z,
  input  logic signed [COORD_WIDTH-1:0] p1_x,
  input  logic signed [COORD_WIDTH-1:0] p1_y,
  input  logic signed [COORD_WIDTH-1:0] p1_z,
  input  logic signed [COORD_WIDTH-1:0] p2_x,
  input  logic signed [COORD_WIDTH-1:0] p2_y,
  input  logic signed [COORD_WIDTH-1:0] p2_z,
  input  logic signed [COORD_WIDTH-1:0] p3_x,
  input  logic signed [COORD_WIDTH-1:0] p3_y,
  input  logic signed [COORD_WIDTH-1:0] p3_z,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    row_index,
  output logic signed [COORD_WIDTH:0]   edge_col0,
  output logic signed [COORD_WIDTH:0]   edge_col1,
  output logic signed [COORD_WIDTH:0]   edge_col2,
  output logic signed [INV_WIDTH-1:0]   invt_col0,
  output logic signed [INV_WIDTH-1:0]   invt_col1,
  output logic signed [INV_WIDTH-1:0]   invt_col2,
  output logic signed [COORD_WIDTH-1:0] offset_comp,
  output logic [DET_WIDTH-1:0]          abs_det,
  output logic                          singular,
  output logic                          last_row
);

  localparam int CW    = COORD_WIDTH;
  localparam int EW    = CW + 1;
  localparam int CFW   = 2 * CW + 3;
  localparam int DETW  = 3 * CW + 6;
  localparam int P_OFF = 9 * EW;
  localparam int C_OFF = P_OFF + 3 * CW;
  localparam int M_OFF = C_OFF + 9 * CFW;
  localparam int N_OFF = M_OFF + DETW;
  localparam int A_OFF = N_OFF + 1;
  localparam int S_OFF = A_OFF + DET_WIDTH;
  localparam int QW    = S_OFF + 1;

  logic signed [CW-1:0]  pt [12];

  // Front end to queue.
  logic                  f_valid;
  logic                  f_ready;
  logic signed [EW-1:0]  f_e   [9];
  logic signed [CW-1:0]  f_p0  [3];
  logic signed [CFW-1:0] f_cof [9];
  logic [DETW-1:0]       f_mag;
  logic                  f_neg;
  logic [DET_WIDTH-1:0]  f_abs;
  logic                  f_sing;
  logic [QW-1:0]         q_din;

  // Queue to row engine.
  logic                  b_valid;
  logic                  b_pop;
  logic [QW-1:0]         q_dout;
  logic signed [EW-1:0]  b_e   [9];
  logic signed [CW-1:0]  b_p0  [3];
  logic signed [CFW-1:0] b_cof [9];

  logic signed [EW-1:0]  o_edge [3];
  logic [INV_WIDTH-1:0]  o_inv  [3];

  assign pt[0]  = p0_x;
  assign pt[1]  = p0_y;
  assign pt[2]  = p0_z;
  assign pt[3]  = p1_x;
  assign pt[4]  = p1_y;
  assign pt[5]  = p1_z;
  assign pt[6]  = p2_x;
  assign pt[7]  = p2_y;
  assign pt[8]  = p2_z;
  assign pt[9]  = p3_x;
  assign pt[10] = p3_y;
  assign pt[11] = p3_z;

  tam_front #(.CW(CW), .F(COORD_FRAC_BITS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .pt        (pt),
    .q_valid   (f_valid),
    .q_ready   (f_ready),
    .e_q       (f_e),
    .p0_q      (f_p0),
    .cof_q     (f_cof),
    .det_mag   (f_mag),
    .det_neg   (f_neg),
    .abs_det_q (f_abs),
    .sing_q    (f_sing)
  );

  // A queued request carries everything the row engine needs for one item.
  always_comb begin
    q_din = '0;
    for (int n = 0; n < 9; n++) begin
      q_din[n*EW +: EW]          = f_e[n];
      q_din[C_OFF + n*CFW +: CFW] = f_cof[n];
    end
    for (int n = 0; n < 3; n++) begin
      q_din[P_OFF + n*CW +: CW] = f_p0[n];
    end
    q_din[M_OFF +: DETW]      = f_mag;
    q_din[N_OFF]              = f_neg;
    q_din[A_OFF +: DET_WIDTH] = f_abs;
    q_din[S_OFF]              = f_sing;
  end

  tam_fifo #(.WIDTH(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .din      (q_din),
    .rd_valid (b_valid),
    .rd_ready (b_pop),
    .dout     (q_dout)
  );

  always_comb begin
    for (int n = 0; n < 9; n++) begin
      b_e[n]   = q_dout[n*EW +: EW];
      b_cof[n] = q_dout[C_OFF + n*CFW +: CFW];
    end
    for (int n = 0; n < 3; n++) begin
      b_p0[n] = q_dout[P_OFF + n*CW +: CW];
    end
  end

  tam_back #(.CW(CW), .F(COORD_FRAC_BITS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (b_valid),
    .q_pop     (b_pop),
    .e_q       (b_e),
    .p0_q      (b_p0),
    .cof_q     (b_cof),
    .det_mag   (q_dout[M_OFF +: DETW]),
    .det_neg   (q_dout[N_OFF]),
    .abs_det_q (q_dout[A_OFF +: DET_WIDTH]),
    .sing_q    (q_dout[S_OFF]),
    .o_valid   (out_valid),
    .o_ready   (out_ready),
    .o_row     (row_index),
    .o_edge    (o_edge),
    .o_inv     (o_inv),
    .o_off     (offset_comp),
    .o_abs     (abs_det),
    .o_sing    (singular),
    .o_last    (last_row)
  );

  assign edge_col0 = o_edge[0];
  assign edge_col1 = o_edge[1];
  assign edge_col2 = o_edge[2];
  assign invt_col0 = o_inv[0];
  assign invt_col1 = o_inv[1];
  assign invt_col2 = o_inv[2];

`ifndef SYNTHESIS
  // The final-row mark travels with row index two and nowhere else.
  a_last_row: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last_row == (row_index == 2'd2)))
    else $error("last_row does not match row_index");

  // A singular matrix delivers an all-zero inverse row.
  a_sing_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && singular) |->
      (invt_col0 == '0 && invt_col1 == '0 && invt_col2 == '0))
    else $error("singular row with nonzero inverse");

  // After a row other than the last is taken, the next one follows in order.
  a_row_order: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && !last_row) |=>
      (!out_valid || (row_index == $past(row_index) + 2'd1)))
    else $error("row results out of order");
`endif

endmodule
